### rtl/region_to_cam_block_splitter_assert.svh
// region_to_cam_block_splitter_assert.svh: assertion macros for the block splitter
// depends on nothing; included by the top level
`ifndef REGION_TO_CAM_BLOCK_SPLITTER_ASSERT_SVH
`define REGION_TO_CAM_BLOCK_SPLITTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RCBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rcbs_pkg.sv
// rcbs_pkg: beat types, command/status structs and constants of the block splitter
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package rcbs_pkg;

	// input beat
	typedef struct packed {
		logic        mode;
		logic [28:0] word_address;
		logic [24:0] word_count;
	} rcbs_in_t;

	// output beat, one per block
	typedef struct packed {
		logic [4:0]  entry_index;
		logic [31:0] cam_data;
		logic [31:0] cam_mask;
		logic [15:0] data_offset;
		logic [11:0] data_start;
		logic [24:0] block_words;
		logic [1:0]  status;
		logic        last;
	} rcbs_out_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic step;
	} rcbs_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic in_clear;
		logic in_empty;
		logic blk_last;
	} rcbs_stat_t;

	localparam logic       MODE_ADD        = 1'b0;
	localparam logic       MODE_CLEAR      = 1'b1;
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_ENTRY = 2'd1;
	localparam logic [1:0] STATUS_NO_DATA  = 2'd2;
	localparam logic [23:0] START_MASK     = 24'hffffff;
	localparam logic [5:0] BLOCKS_PER_ITEM = 6'd32;

endpackage

`default_nettype wire

### rtl/rcbs_ctrl.sv
// rcbs_ctrl: controller state machine and output valid of the block splitter
// depends on rcbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcbs_ctrl import rcbs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire rcbs_stat_t stat,
	output rcbs_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} rcbs_state_t;

	rcbs_state_t state_q, state_d;
	logic        out_valid_q;
	logic        accept;

	// handshake and commands
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.clear = accept & (stat.in_clear == MODE_CLEAR);
		cmd.load  = accept & (stat.in_clear == MODE_ADD) & ~stat.in_empty;
		cmd.step  = (state_q == ST_RUN) & (~out_valid_q | out_ready);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.step && stat.blk_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// output register fills on a step, drains when taken
			if (cmd.step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### rtl/rcbs_datapath.sv
// rcbs_datapath: allocators, region cursor, block split and output register
// depends on rcbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcbs_datapath import rcbs_pkg::*; #(
	parameter int CAM_ENTRIES = 32,
	parameter int DATA_WORDS  = 4096
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rcbs_in_t  in_data,
	input  wire rcbs_cmd_t cmd,
	output rcbs_stat_t     stat,
	output rcbs_out_t      out_data
);

	localparam int EW = $clog2(CAM_ENTRIES + 1);
	localparam int DW = $clog2(DATA_WORDS + 1);
	localparam int SW = 26;

	logic [EW-1:0] next_entry_q;
	logic [DW-1:0] next_data_q;
	logic [28:0]   cursor_q;
	logic [24:0]   remain_q;
	logic [5:0]    blk_cnt_q;
	rcbs_out_t     out_q;

	logic [23:0]   align_m;
	logic [24:0]   smear;
	logic [23:0]   mask;
	logic [24:0]   words;
	logic [24:0]   remain_next;
	logic [SW-1:0] data_end;
	logic          entry_full;
	logic          data_full;
	rcbs_out_t     blk;

	// largest aligned block: trailing zeros of the cursor and the highest
	// power of two not above the remaining count, both as low-bit masks
	always_comb begin
		align_m = 24'((cursor_q - 29'd1) & ~cursor_q);
		smear   = remain_q;
		smear   = smear | (smear >> 1);
		smear   = smear | (smear >> 2);
		smear   = smear | (smear >> 4);
		smear   = smear | (smear >> 8);
		smear   = smear | (smear >> 16);
		mask    = align_m & smear[24:1] & START_MASK;
		words   = {1'b0, mask} + 25'd1;
	end

	// allocator checks
	assign remain_next = remain_q - words;
	assign data_end    = SW'(next_data_q) + {1'b0, words};
	assign entry_full  = (next_entry_q >= EW'(CAM_ENTRIES)) || (blk_cnt_q >= BLOCKS_PER_ITEM);
	assign data_full   = data_end > SW'(DATA_WORDS);

	// result of this block
	always_comb begin
		blk = '0;
		if (entry_full) begin
			blk.status = STATUS_NO_ENTRY;
			blk.last   = 1'b1;
		end else if (data_full) begin
			blk.status = STATUS_NO_DATA;
			blk.last   = 1'b1;
		end else begin
			blk.entry_index = 5'(next_entry_q);
			blk.cam_data    = {3'b000, cursor_q[28:24], cursor_q[23:0] & ~mask};
			blk.cam_mask    = {3'b111, ~cursor_q[28:24], ~cursor_q[23:0] & ~mask};
			blk.data_offset = 16'(next_data_q) - cursor_q[15:0];
			blk.data_start  = 12'(next_data_q);
			blk.block_words = words;
			blk.status      = STATUS_OK;
			blk.last        = (remain_next == 25'd0);
		end
	end

	// status to the controller
	always_comb begin
		stat.in_clear = in_data.mode;
		stat.in_empty = (in_data.word_count == 25'd0);
		stat.blk_last = blk.last;
	end

	// allocator and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_entry_q <= '0;
			next_data_q  <= '0;
			cursor_q     <= '0;
			remain_q     <= '0;
			blk_cnt_q    <= '0;
		end else if (cmd.clear) begin
			next_entry_q <= '0;
			next_data_q  <= '0;
			cursor_q     <= '0;
			remain_q     <= '0;
			blk_cnt_q    <= '0;
		end else if (cmd.load) begin
			cursor_q  <= in_data.word_address;
			remain_q  <= in_data.word_count;
			blk_cnt_q <= '0;
		end else if (cmd.step && blk.status == STATUS_OK) begin
			next_entry_q <= next_entry_q + EW'(1);
			next_data_q  <= DW'(data_end);
			cursor_q     <= cursor_q + 29'(words);
			remain_q     <= remain_next;
			blk_cnt_q    <= blk_cnt_q + 6'd1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.step) out_q <= blk;
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

### rtl/region_to_cam_block_splitter.sv
// region_to_cam_block_splitter: top level, controller plus datapath
// depends on rcbs_pkg, rcbs_ctrl, rcbs_datapath, region_to_cam_block_splitter_assert.svh
//
// Usage:
// - input channel in_valid/in_ready/in_data: an add beat names a region by word
//   address and word count; a clear beat resets the entry and data allocators
// - output channel out_valid/out_ready/out_data: one beat per aligned
//   power-of-two block, carrying the CAM data/mask words, the entry and the
//   reserved data run; an error beat ends an item that ran out of entries or
//   data space; last marks the final beat of an item
// - the first beat of an add item is split from the region cursor, which is
//   loaded when its input beat is taken, into the output register; then one
//   beat per cycle from the block split step while the receiver takes them
// - a clear beat or a zero count gives no beat and does not hold the input side
// - a stalled receiver holds the output register and the split step waits;
//   the next input beat is taken as soon as the final block has been split
// - reset clears both allocators and the controller; the block is ready for
//   input as soon as reset is released
`timescale 1ns / 1ps
`default_nettype none

`include "region_to_cam_block_splitter_assert.svh"

module region_to_cam_block_splitter import rcbs_pkg::*; #(
	parameter int CAM_ENTRIES = 32,
	parameter int DATA_WORDS  = 4096
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire rcbs_in_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output rcbs_out_t     out_data
);

	rcbs_cmd_t  cmd;
	rcbs_stat_t stat;

	// controller
	rcbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	rcbs_datapath #(
		.CAM_ENTRIES (CAM_ENTRIES),
		.DATA_WORDS  (DATA_WORDS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

	// checks
	`RCBS_ASSERT_IMPL(a_err_is_last, clk, arst_n, out_valid && out_data.status != STATUS_OK, out_data.last, "error beat without last")
	`RCBS_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && out_data.status != STATUS_OK, out_data.block_words == 25'd0 && out_data.entry_index == 5'd0, "error beat carries block fields")
	`RCBS_ASSERT_IMPL(a_ok_pow2, clk, arst_n, out_valid && out_data.status == STATUS_OK, $onehot(out_data.block_words), "block size not a power of two")
	`RCBS_ASSERT_NEXT(a_busy_after_load, clk, arst_n, in_valid && in_ready && in_data.mode == MODE_ADD && in_data.word_count != 25'd0, !in_ready, "ready while splitting a region")

endmodule

`default_nettype wire

### test/testbench.sv
// testbench for region_to_cam_block_splitter, uses rcbs_pkg: directed table then
// random regions; beats checked against a block-split predictor or a known result
`timescale 1ns / 1ps

module testbench;
	import rcbs_pkg::*;

	localparam int CAM_ENTRIES  = 32;
	localparam int DATA_WORDS   = 4096;
	localparam int DIRECTED     = 22;
	localparam int RANDOM_ITEMS = 270;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 300;

	localparam rcbs_out_t NO_RESULT    = '0;
	localparam rcbs_out_t ERR_NO_ENTRY = {122'd0, STATUS_NO_ENTRY, 1'b1};
	localparam rcbs_out_t ERR_NO_DATA  = {122'd0, STATUS_NO_DATA, 1'b1};

	// one directed row: input beat, plus a hand-written result when known is set
	typedef struct packed {
		rcbs_in_t  beat;
		logic      known;
		rcbs_out_t result;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	rcbs_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	rcbs_out_t out_data;

	// allocator state of the predictor
	int unsigned alloc_entry = 0;
	int unsigned alloc_data = 0;
	rcbs_out_t   split_blocks[$];
	rcbs_out_t   pending_blocks[$];

	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	bit          quiet = 1'b0;
	bit          hold_off_req = 1'b0;
	row_t        directed_rows [DIRECTED];

	region_to_cam_block_splitter #(
		.CAM_ENTRIES(CAM_ENTRIES),
		.DATA_WORDS (DATA_WORDS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// clock, 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// split one region into aligned power-of-two blocks, filling split_blocks
	function automatic void split_region(input rcbs_in_t beat);
		logic [28:0] cursor;
		logic [24:0] remaining;
		logic [23:0] mask;
		logic [24:0] words;
		int unsigned placed;
		rcbs_out_t   blk;
		split_blocks.delete();
		if (beat.mode == MODE_CLEAR) begin
			alloc_entry = 0;
			alloc_data = 0;
			return;
		end
		cursor = beat.word_address;
		remaining = beat.word_count;
		placed = 0;
		while (remaining != 0) begin
			blk = '0;
			// entries exhausted or per-item block limit reached
			if (alloc_entry >= CAM_ENTRIES || placed >= BLOCKS_PER_ITEM) begin
				blk.status = STATUS_NO_ENTRY;
				split_blocks.push_back(blk);
				break;
			end
			// shrink the mask until it fits the length and the alignment
			mask = START_MASK;
			while (25'(mask) >= remaining || (29'(mask) & cursor) != 0)
				mask = mask >> 1;
			words = 25'(mask) + 25'd1;
			if (alloc_data + words > DATA_WORDS) begin
				blk.status = STATUS_NO_DATA;
				split_blocks.push_back(blk);
				break;
			end
			blk.entry_index = alloc_entry[4:0];
			blk.cam_data    = {3'b000, cursor} & ~{8'h00, mask};
			blk.cam_mask    = ~{3'b000, cursor} & ~{8'h00, mask};
			blk.data_offset = 16'(alloc_data) - cursor[15:0];
			blk.data_start  = 12'(alloc_data);
			blk.block_words = words;
			blk.status      = STATUS_OK;
			split_blocks.push_back(blk);
			remaining = remaining - words;
			cursor = cursor + 29'(words);
			alloc_data = alloc_data + words;
			alloc_entry = alloc_entry + 1;
			placed = placed + 1;
		end
		// mark the final beat of the item
		if (split_blocks.size() != 0) begin
			blk = split_blocks.pop_back();
			blk.last = 1'b1;
			split_blocks.push_back(blk);
		end
	endfunction

	// random region: mostly small adds, some huge or zero counts, some clears
	function automatic rcbs_in_t random_item();
		rcbs_in_t    beat;
		int unsigned pick;
		beat.mode = MODE_ADD;
		beat.word_address = 29'($urandom);
		beat.word_count = 25'($urandom_range(1, 96));
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			beat.mode = MODE_CLEAR;
			beat.word_count = 25'($urandom);
		end else if (pick < 14) begin
			beat.word_count = '0;
		end else if (pick < 22) begin
			beat.word_count = 25'($urandom);
		end else if (pick < 34) begin
			beat.word_count = 25'($urandom_range(1, 4096));
		end
		// aligned starts and starts near the top of the address space
		pick = $urandom_range(0, 9);
		if (pick < 2)
			beat.word_address[11:0] = '0;
		else if (pick == 2)
			beat.word_address = 29'h1fffffff - 29'($urandom_range(0, 63));
		return beat;
	endfunction

	// offer one beat, then queue what it should produce
	task automatic send_beat(input row_t row);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= row.beat;
		do @(posedge clk); while (!in_ready);
		split_region(row.beat);
		if (row.known)
			pending_blocks.push_back(row.result);
		else
			foreach (split_blocks[k]) pending_blocks.push_back(split_blocks[k]);
	endtask

	// compare one output beat with the oldest expected block
	task automatic check_block(input rcbs_out_t got);
		rcbs_out_t want;
		if (pending_blocks.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected output beat %h", got);
			return;
		end
		want = pending_blocks.pop_front();
		if (got.entry_index !== want.entry_index || got.cam_data !== want.cam_data ||
				got.cam_mask !== want.cam_mask || got.data_offset !== want.data_offset ||
				got.data_start !== want.data_start || got.block_words !== want.block_words ||
				got.status !== want.status || got.last !== want.last) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch exp: e=%0d d=%h m=%h o=%h s=%h w=%h st=%0d l=%b",
					want.entry_index, want.cam_data, want.cam_mask, want.data_offset,
					want.data_start, want.block_words, want.status, want.last);
				$display("         got: e=%0d d=%h m=%h o=%h s=%h w=%h st=%0d l=%b",
					got.entry_index, got.cam_data, got.cam_mask, got.data_offset,
					got.data_start, got.block_words, got.status, got.last);
			end
		end
	endtask

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_block(out_data);
	end

	// receiver: random ready bursts, one long hold-off, none at the end
	initial begin : drain
		int unsigned burst;
		bit          held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			burst = $urandom_range(1, 10);
			if (hold_off_req && !held) begin
				out_ready <= 1'b0;
				held = 1'b1;
				burst = HOLD_CYCLES;
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
			end
			repeat (burst) @(posedge clk);
		end
	end

	// stimulus
	initial begin : stimulus
		row_t row;
		directed_rows = '{
			// first add after reset, single word at address zero
			{MODE_ADD, 29'h0000000, 25'd1, 1'b1,
				5'd0, 32'h0000_0000, 32'hffff_ffff, 16'h0000, 12'h000, 25'd1, STATUS_OK, 1'b1},
			{MODE_CLEAR, 29'h1fffffff, 25'h1ffffff, 1'b0, NO_RESULT},
			{MODE_ADD, 29'h0000000, 25'd0, 1'b0, NO_RESULT},
			// top address, offset wraps
			{MODE_ADD, 29'h1fffffff, 25'd1, 1'b1,
				5'd0, 32'h1fff_ffff, 32'he000_0000, 16'h0001, 12'h000, 25'd1, STATUS_OK, 1'b1},
			{MODE_ADD, 29'h0000000, 25'd16, 1'b0, NO_RESULT},
			{MODE_ADD, 29'h0000003, 25'd13, 1'b0, NO_RESULT},
			// cursor wraps past the top
			{MODE_ADD, 29'h1ffffffe, 25'd4, 1'b0, NO_RESULT},
			{MODE_ADD, 29'h0abcdef0, 25'd255, 1'b0, NO_RESULT},
			{MODE_CLEAR, 29'h0000000, 25'd0, 1'b0, NO_RESULT},
			// whole data space in one block, then out of data space
			{MODE_ADD, 29'h0000000, 25'd4096, 1'b1,
				5'd0, 32'h0000_0000, 32'hffff_f000, 16'h0000, 12'h000, 25'd4096, STATUS_OK,
				1'b1},
			{MODE_ADD, 29'h0000000, 25'd1, 1'b1, ERR_NO_DATA},
			{MODE_CLEAR, 29'h0000000, 25'd0, 1'b0, NO_RESULT},
			// largest block is bigger than the data space
			{MODE_ADD, 29'h0000000, 25'h1000000, 1'b1, ERR_NO_DATA},
			{MODE_ADD, 29'h0000000, 25'h1ffffff, 1'b0, NO_RESULT},
			{MODE_CLEAR, 29'h0000000, 25'd0, 1'b0, NO_RESULT},
			// use up all entries, the fourth item runs out midway, the next finds none
			{MODE_ADD, 29'h0000001, 25'd2046, 1'b0, NO_RESULT},
			{MODE_ADD, 29'h0ffffff1, 25'd30, 1'b0, NO_RESULT},
			{MODE_ADD, 29'h0000003, 25'd7, 1'b0, NO_RESULT},
			{MODE_ADD, 29'h0000009, 25'd3, 1'b0, NO_RESULT},
			{MODE_ADD, 29'h0000000, 25'd1, 1'b1, ERR_NO_ENTRY},
			{MODE_ADD, 29'h15555555, 25'd0, 1'b0, NO_RESULT},
			{MODE_CLEAR, 29'h0aaaaaaa, 25'h0aaaaaa, 1'b0, NO_RESULT}
		};

		// reset
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[r])
			send_beat(directed_rows[r]);

		// random regions, long receiver hold-off early, no idling at the end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 60)
				hold_off_req = 1'b1;
			if (i == RANDOM_ITEMS - 30)
				quiet = 1'b1;
			row.beat = random_item();
			row.known = 1'b0;
			row.result = NO_RESULT;
			send_beat(row);
		end
		in_valid <= 1'b0;

		// drain
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0 && pending_blocks.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/rcbs_pkg.sv
rtl/rcbs_ctrl.sv
rtl/rcbs_datapath.sv
rtl/region_to_cam_block_splitter.sv
test/testbench.sv
